// ----- src/pcrld_pkg.sv -----
// ----------------------------------------------------------------------------
// pcrld_pkg
// Shared types and constants of the packed code run-length decoder.
// ----------------------------------------------------------------------------
package pcrld_pkg;

    localparam int DEF_BOARD_TILES = 4096;
    localparam int CODE_W_NARROW   = 12;
    localparam int CODE_W_WIDE     = 13;
    localparam int BUF_W           = 20;
    localparam int HELD_W          = 5;
    localparam int CFG_W           = 4;
    localparam int PAIR_BIT        = 8;

    localparam logic [CFG_W-1:0]  CFG_RESET   = CFG_W'(CODE_W_NARROW);
    localparam logic [CFG_W-1:0]  CFG_WIDE    = CFG_W'(CODE_W_WIDE);
    localparam logic [HELD_W-1:0] HELD_NARROW = HELD_W'(CODE_W_NARROW);
    localparam logic [HELD_W-1:0] HELD_WIDE   = HELD_W'(CODE_W_WIDE);

    typedef struct packed {
        logic [7:0] data_byte;
        logic       start_of_board;
    } t_in;

    typedef struct packed {
        logic [11:0] run_start;
        logic [8:0]  run_length;
        logic [12:0] first_tile;
        logic [12:0] second_tile;
        logic        paired;
        logic        board_full;
    } t_out;

    // One classified byte handed from the front to the back.
    typedef struct packed {
        logic        sob;
        logic        has_code;
        logic        is_repeat;
        logic [12:0] code;
    } t_qent;

endpackage

// ----- src/packed_code_run_length_decoder.sv -----
// ----------------------------------------------------------------------------
// packed_code_run_length_decoder
// Byte stream in, run descriptors out, for bit-packed run-length tile data.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: one byte plus a start-of-board flag per transaction,
//   taken at an edge with i_in_valid high and o_in_stall low.
//   Output channel: one run descriptor per transaction, taken at an edge
//   with o_out_valid high and i_out_stall low. A byte gives zero or one run.
//   Configuration: i_cfg_we with i_cfg_wdata sets the code width (13 selects
//   13-bit codes, any other value 12-bit). Write it only while idle.
//   Throughput: one byte per cycle while o_in_stall is low. Each of the code
//   gatherer and run engine handles one entry a cycle unless stalled, with a
//   two-entry queue between; a run goes from the queue to the output register.
//   Reset (synchronous, active low) empties the queue and output register,
//   clears the decoder and sets the code width to 12.
//   A stalled output holds its descriptor; the run engine stops, the queue
//   fills, and o_in_stall rises once both entries are taken.
// ----------------------------------------------------------------------------
module packed_code_run_length_decoder
    import pcrld_pkg::*;
#(
    parameter int BOARD_TILES = DEF_BOARD_TILES
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_wdata,
    input  logic             i_in_valid,
    input  t_in              i_in_data,
    output logic             o_in_stall,
    output logic             o_out_valid,
    output t_out             o_out_data,
    input  logic             i_out_stall
);

    logic  accept;
    logic  q_full, q_avail, q_pop;
    t_qent front_ent, back_ent;

    // accept whenever the queue has room
    assign o_in_stall = q_full;
    assign accept     = i_in_valid && !q_full;

    // front: gather bits and classify the code of each byte
    pcrld_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_accept    (accept),
        .i_data      (i_in_data),
        .o_ent       (front_ent)
    );

    // queue: decouple the front from an output stall
    pcrld_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_ent   (front_ent),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_avail (q_avail),
        .o_ent   (back_ent)
    );

    // back: repeat, pair and board bookkeeping, registered output
    pcrld_back #(
        .BOARD_TILES (BOARD_TILES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_avail     (q_avail),
        .i_ent       (back_ent),
        .o_pop       (q_pop),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

// ----- src/pcrld_front.sv -----
// ----------------------------------------------------------------------------
// pcrld_front
// Gathers bytes into 12 or 13 bit codes and classifies each code.
// ----------------------------------------------------------------------------
module pcrld_front
    import pcrld_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_wdata,
    input  logic             i_accept,
    input  t_in              i_data,
    output t_qent            o_ent
);

    logic [CFG_W-1:0]  r_cfg;
    logic [BUF_W-1:0]  r_buf,  n_buf;
    logic [HELD_W-1:0] r_held, n_held;

    logic              wide;
    logic [HELD_W-1:0] cw;
    logic [BUF_W-1:0]  base_buf, cat_buf;
    logic [HELD_W-1:0] base_held, cat_held;
    logic [12:0]       code;

    always_comb begin
        wide      = (r_cfg == CFG_WIDE);
        cw        = wide ? HELD_WIDE : HELD_NARROW;
        base_buf  = i_data.start_of_board ? '0 : r_buf;
        base_held = i_data.start_of_board ? '0 : r_held;
        cat_buf   = base_buf | ({{(BUF_W-8){1'b0}}, i_data.data_byte} << base_held[3:0]);
        cat_held  = base_held + HELD_W'(8);
        code      = wide ? cat_buf[12:0] : {1'b0, cat_buf[11:0]};

        o_ent.sob       = i_data.start_of_board;
        o_ent.has_code  = (cat_held >= cw);
        o_ent.code      = code;
        o_ent.is_repeat = wide ? code[12] : code[11];

        n_buf  = cat_buf;
        n_held = cat_held;
        if (o_ent.has_code) begin
            n_buf  = wide ? (cat_buf >> CODE_W_WIDE) : (cat_buf >> CODE_W_NARROW);
            n_held = cat_held - cw;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg  <= CFG_RESET;
            r_buf  <= '0;
            r_held <= '0;
        end else begin
            if (i_cfg_we) begin
                r_cfg <= i_cfg_wdata;
            end
            if (i_accept) begin
                r_buf  <= n_buf;
                r_held <= n_held;
            end
        end
    end

endmodule

// ----- src/pcrld_queue.sv -----
// ----------------------------------------------------------------------------
// pcrld_queue
// Two-entry queue between the front and the back.
// ----------------------------------------------------------------------------
module pcrld_queue
    import pcrld_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_qent i_ent,
    input  logic  i_pop,
    output logic  o_full,
    output logic  o_avail,
    output t_qent o_ent
);

    t_qent      r_mem [2];
    logic       r_wr, r_rd;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_avail = (r_cnt != 2'd0);
    assign o_ent   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_ent;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= ~r_wr;
            end
            if (i_pop) begin
                r_rd <= ~r_rd;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

endmodule

// ----- src/pcrld_back.sv -----
// ----------------------------------------------------------------------------
// pcrld_back
// Applies repeat and pair codes, tracks the board index, registers results.
// ----------------------------------------------------------------------------
module pcrld_back
    import pcrld_pkg::*;
#(
    parameter int BOARD_TILES = DEF_BOARD_TILES
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_avail,
    input  t_qent i_ent,
    output logic  o_pop,
    input  logic  i_out_stall,
    output logic  o_out_valid,
    output t_out  o_out_data
);

    localparam int BW = $clog2(BOARD_TILES + 1);
    localparam logic [BW-1:0] BOARD = BW'(BOARD_TILES);

    logic [BW-1:0] r_bi,    n_bi;
    logic [7:0]    r_count, n_count;
    logic          r_armed, n_armed;
    logic [12:0]   r_held,  n_held;
    logic          r_hval,  n_hval;
    logic          r_out_valid;
    t_out          r_out,   n_out;
    logic          emit;

    logic [BW-1:0] bi, room;
    logic [15:0]   room_ext, half_ext, count_ext;
    logic [7:0]    n_run;
    logic [8:0]    len;

    assign o_pop       = i_avail && (!r_out_valid || !i_out_stall);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_comb begin
        // start of board clears everything ahead of the byte
        bi      = i_ent.sob ? '0 : r_bi;
        n_bi    = bi;
        n_count = i_ent.sob ? 8'd1 : r_count;
        n_armed = i_ent.sob ? 1'b0 : r_armed;
        n_held  = i_ent.sob ? 13'd0 : r_held;
        n_hval  = i_ent.sob ? 1'b0 : r_hval;
        emit    = 1'b0;

        room      = BOARD - bi;
        room_ext  = 16'(room);
        half_ext  = room_ext >> 1;
        count_ext = {8'd0, n_count};
        n_run     = '0;
        len       = '0;
        n_out     = r_out;

        if (bi < BOARD && i_ent.has_code) begin
            if (i_ent.is_repeat) begin
                if (i_ent.code[PAIR_BIT]) begin
                    n_armed = 1'b1;
                end
                n_count = i_ent.code[7:0];
            end else if (n_count == 8'd1) begin
                len  = 9'd1;
                emit = 1'b1;
                n_out.first_tile  = i_ent.code;
                n_out.second_tile = i_ent.code;
                n_out.paired      = 1'b0;
            end else if (n_armed) begin
                if (!n_hval) begin
                    n_held = i_ent.code;
                    n_hval = 1'b1;
                end else begin
                    n_run = (count_ext > half_ext) ? half_ext[7:0] : n_count;
                    len   = {n_run, 1'b0};
                    emit  = 1'b1;
                    n_out.first_tile  = n_held;
                    n_out.second_tile = i_ent.code;
                    n_out.paired      = 1'b1;
                    n_held  = 13'd0;
                    n_hval  = 1'b0;
                    n_armed = 1'b0;
                    n_count = 8'd1;
                end
            end else begin
                n_run = (count_ext > room_ext) ? room_ext[7:0] : n_count;
                len   = {1'b0, n_run};
                emit  = 1'b1;
                n_out.first_tile  = i_ent.code;
                n_out.second_tile = i_ent.code;
                n_out.paired      = 1'b0;
                n_count = 8'd1;
            end
        end

        if (emit) begin
            n_bi = bi + BW'(len);
        end
        n_out.run_start  = 12'(16'(bi));
        n_out.run_length = len;
        n_out.board_full = (n_bi >= BOARD);
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && emit) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bi        <= '0;
            r_count     <= 8'd1;
            r_armed     <= 1'b0;
            r_held      <= '0;
            r_hval      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_bi    <= n_bi;
                r_count <= n_count;
                r_armed <= n_armed;
                r_held  <= n_held;
                r_hval  <= n_hval;
            end
            if (o_pop && emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

// ----- src/pcrld_checker.sv -----
// ----------------------------------------------------------------------------
// pcrld_checker
// Port-level checks of the run-length decoder, bound to the top level.
// ----------------------------------------------------------------------------
module pcrld_checker
    import pcrld_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic o_out_valid,
    input t_out o_out_data,
    input logic i_out_stall
);

    // a stalled descriptor holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled run descriptor changed");

    // pair runs always cover whole pairs
    a_even: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.paired |-> !o_out_data.run_length[0])
        else $error("paired run with odd length");

    // single runs repeat one tile
    a_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.paired |->
            o_out_data.first_tile == o_out_data.second_tile)
        else $error("single run with two tiles");

    // reset empties the output register
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

endmodule

bind packed_code_run_length_decoder pcrld_checker u_pcrld_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .o_out_data  (o_out_data),
    .i_out_stall (i_out_stall)
);
